// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge once reset is released
`define DRK_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define DRK_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/drk_pkg.sv -----
// ----------------------------------------------------------------------------
// drk_pkg
// shared constants and types of the dynamic range k-th smallest core
// ----------------------------------------------------------------------------
package drk_pkg;

   // store geometry
   localparam int DEPTH      = 1024;
   localparam int VALUE_BITS = 16;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = ADDR_W + 1;

   // request / response field widths
   localparam int POS_W  = 10;
   localparam int RANK_W = 11;
   localparam int KV_W   = 16;

   // request opcodes
   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // query command from the front end to the selection sequencer
   typedef struct packed {
      logic              start;
      logic              err;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [RANK_W-1:0] rank;
   } drk_cmd_type;

   // finished query from the selection sequencer
   typedef struct packed {
      logic                  valid;
      logic                  err;
      logic [VALUE_BITS-1:0] value;
   } drk_res_type;

endpackage

// ----- hdl/drk_store.sv -----
// ----------------------------------------------------------------------------
// drk_store
// value memory with one write and one registered read port, zeroed by a
// sweep after reset
// ----------------------------------------------------------------------------
module drk_store import drk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [VALUE_BITS-1:0] rd_data,
   output logic                  clear_done
);

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  clr_done_ff, clr_done_in;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;

   // clearing sweep, one entry per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_done_in = clr_done_ff;
      if (!clr_done_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_done_ff <= clr_done_in;
      end
   end

   // write port shared between sweep and updates
   always_comb begin
      if (!clr_done_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = wr_en;
         mem_waddr = wr_addr;
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_done = clr_done_ff;

endmodule

// ----- hdl/drk_select.sv -----
// ----------------------------------------------------------------------------
// drk_select
// radix selection sequencer: one range scan per value bit through a shared
// compare and count unit
// ----------------------------------------------------------------------------
module drk_select import drk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  drk_cmd_type           cmd,
   input  logic                  res_take,
   input  logic [VALUE_BITS-1:0] rd_data,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr,
   output logic                  idle,
   output drk_res_type           res
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     lo_ff, lo_in;
   logic [ADDR_W-1:0]     hi_ff, hi_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic [CNT_W-1:0]      zeros_ff, zeros_in;
   logic [VALUE_BITS-1:0] prefix_ff, prefix_in;
   logic [VALUE_BITS-1:0] decided_ff, decided_in;
   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic                  err_ff, err_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  match;
   logic                  go_high;

   // shared compare: entry matches the prefix and has a zero in the current bit
   assign match = ((rd_data & decided_ff) == prefix_ff) && ((rd_data & cur_ff) == '0);

   // rank lies above the zero group
   assign go_high = 32'(rank_ff) > 32'(zeros_ff);

   assign rd_vld_in = (state_ff == ST_SCAN);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      addr_in    = addr_ff;
      rank_in    = rank_ff;
      zeros_in   = zeros_ff;
      prefix_in  = prefix_ff;
      decided_in = decided_ff;
      cur_in     = cur_ff;
      err_in     = err_ff;

      // count matches as read data returns
      if (rd_vld_ff && match) begin
         zeros_in = zeros_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               lo_in      = cmd.lo;
               hi_in      = cmd.hi;
               addr_in    = cmd.lo;
               rank_in    = cmd.rank;
               zeros_in   = '0;
               prefix_in  = '0;
               decided_in = '0;
               cur_in     = {1'b1, {(VALUE_BITS-1){1'b0}}};
               err_in     = cmd.err;
               state_in   = cmd.err ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (go_high) begin
               rank_in   = rank_ff - RANK_W'(zeros_ff);
               prefix_in = prefix_ff | cur_ff;
            end
            decided_in = decided_ff | cur_ff;
            zeros_in   = '0;
            addr_in    = lo_ff;
            if (cur_ff[0]) begin
               state_in = ST_DONE;
            end else begin
               cur_in   = cur_ff >> 1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      addr_ff    <= addr_in;
      rank_ff    <= rank_in;
      zeros_ff   <= zeros_in;
      prefix_ff  <= prefix_in;
      decided_ff <= decided_in;
      cur_ff     <= cur_in;
      err_ff     <= err_in;
   end

   // outputs
   assign rd_en     = (state_ff == ST_SCAN);
   assign rd_addr   = addr_ff;
   assign idle      = (state_ff == ST_IDLE);
   assign res.valid = (state_ff == ST_DONE);
   assign res.err   = err_ff;
   assign res.value = err_ff ? '0 : prefix_ff;

endmodule

// ----- hdl/dynamic_range_kth_smallest_core.sv -----
// ----------------------------------------------------------------------------
// dynamic_range_kth_smallest_core
// k-th smallest value over a range of a writable value array
// ----------------------------------------------------------------------------
// channel   | direction | ports
// ----------+-----------+------------------------------------------------------
// request   | in        | req_valid/req_ready, opcode, position, range_end,
//           |           | new_value, rank_k
// response  | out       | rsp_valid/rsp_ready, kth_value, rank_error
//
// an update gives no response
// a query makes one range scan per value bit through the single read port of
// the value memory; a bad query goes to its response with no scan
// after reset the memory is zeroed by a sweep, req_ready stays low
// a finished query waits in the selection unit until the response register is
// free; new requests are taken while a response waits in that register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dynamic_range_kth_smallest_core import drk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [POS_W-1:0]  req_position,
   input  logic [POS_W-1:0]  req_range_end,
   input  logic [KV_W-1:0]   req_new_value,
   input  logic [RANK_W-1:0] req_rank_k,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KV_W-1:0]   rsp_kth_value,
   output logic              rsp_rank_error
);

   logic                  req_fire;
   logic                  clear_done;
   logic                  sel_idle;
   logic                  st_wr_en;
   logic                  sel_rd_en;
   logic [ADDR_W-1:0]     sel_rd_addr;
   logic [VALUE_BITS-1:0] st_rd_data;
   logic [RANK_W-1:0]     range_len;
   logic                  query_err;
   logic                  res_take;
   drk_cmd_type           cmd;
   drk_res_type           res;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KV_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                  rsp_err_ff, rsp_err_in;

   // request handshake
   assign req_ready = clear_done && sel_idle;
   assign req_fire  = req_valid && req_ready;

   // update path
   assign st_wr_en = req_fire && (req_opcode == OP_UPDATE) &&
                     (32'(req_position) < DEPTH);

   // query range and rank checks
   assign range_len = RANK_W'(req_range_end) - RANK_W'(req_position) + 1'b1;
   assign query_err = (req_rank_k == '0) || (req_position > req_range_end) ||
                      (32'(req_range_end) >= DEPTH) || (req_rank_k > range_len);

   assign cmd.start = req_fire && (req_opcode == OP_QUERY);
   assign cmd.err   = query_err;
   assign cmd.lo    = ADDR_W'(req_position);
   assign cmd.hi    = ADDR_W'(req_range_end);
   assign cmd.rank  = req_rank_k;

   drk_store u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (st_wr_en),
      .wr_addr    (ADDR_W'(req_position)),
      .wr_data    (VALUE_BITS'(req_new_value)),
      .rd_en      (sel_rd_en),
      .rd_addr    (sel_rd_addr),
      .rd_data    (st_rd_data),
      .clear_done (clear_done)
   );

   drk_select u_select (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .res_take (res_take),
      .rd_data  (st_rd_data),
      .rd_en    (sel_rd_en),
      .rd_addr  (sel_rd_addr),
      .idle     (sel_idle),
      .res      (res)
   );

   // response register
   assign res_take = res.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = KV_W'(res.value);
         rsp_err_in   = res.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kth_value  = rsp_value_ff;
   assign rsp_rank_error = rsp_err_ff;

   // checks
   `DRK_ASSERT(a_err_zero, rsp_valid && rsp_rank_error |-> rsp_kth_value == '0, "error value")
   `DRK_ASSERT(a_no_wr_in_scan, st_wr_en |-> !sel_rd_en, "memory write during a range scan")
   `DRK_ASSERT_ALWAYS(a_clear_after_reset, $past(reset) |-> !req_ready, "ready after reset")

endmodule

// ----- verif/kth_smallest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_smallest_checker
// watches both channels of the k-th smallest core and checks every response
// ----------------------------------------------------------------------------
// keeps a shadow copy of the value array, applies each accepted update to it,
// and works out the answer of each accepted query at the moment of acceptance
// answers wait in order and are compared field by field with the responses
// ----------------------------------------------------------------------------
module kth_smallest_checker import drk_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_opcode,
   input  logic [POS_W-1:0]  req_position,
   input  logic [POS_W-1:0]  req_range_end,
   input  logic [KV_W-1:0]   req_new_value,
   input  logic [RANK_W-1:0] req_rank_k,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [KV_W-1:0]   rsp_kth_value,
   input  logic              rsp_rank_error,
   output int                mismatch_count,
   output int                answers_pending,
   output int                query_total,
   output int                update_total,
   output int                rejected_total
);

   typedef struct packed {
      logic [KV_W-1:0] value;
      logic            err;
   } kth_answer_type;

   // shadow of the value array and the answers still owed by the core
   logic [VALUE_BITS-1:0] shadow_store [DEPTH];
   kth_answer_type        owed_answers [$];

   // k-th smallest over lo..hi, one value bit at a time from the top
   function automatic kth_answer_type kth_smallest(input int lo, input int hi, input int rank);
      kth_answer_type        ans;
      logic [VALUE_BITS-1:0] prefix;
      logic [VALUE_BITS-1:0] fixed_bits;
      int                    zeros;
      int                    b;
      int                    i;
      ans = '0;
      // zero rank, reversed range, range past the store, rank beyond the range
      if (rank == 0 || lo > hi || hi >= DEPTH || rank > hi - lo + 1) begin
         ans.err = 1'b1;
         return ans;
      end
      prefix     = '0;
      fixed_bits = '0;
      for (b = VALUE_BITS - 1; b >= 0; b--) begin
         zeros = 0;
         for (i = lo; i <= hi; i++)
            if ((shadow_store[i] & fixed_bits) == prefix && !shadow_store[i][b])
               zeros++;
         // more entries needed than carry a 0 here: the answer has a 1
         if (rank > zeros) begin
            rank      -= zeros;
            prefix[b]  = 1'b1;
         end
         fixed_bits[b] = 1'b1;
      end
      ans.value = prefix;
      return ans;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // channel monitor
   always @(posedge clock) begin
      kth_answer_type want;
      if (reset) begin
         owed_answers.delete();
         foreach (shadow_store[i]) shadow_store[i] = '0;
      end else begin
         // response side first: a response always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (owed_answers.size() == 0) begin
               report_mismatch($sformatf("response with no query waiting: value %h error %b",
                                         rsp_kth_value, rsp_rank_error));
            end else begin
               want = owed_answers.pop_front();
               if (rsp_kth_value !== want.value)
                  report_mismatch($sformatf("kth_value %h, expected %h",
                                            rsp_kth_value, want.value));
               if (rsp_rank_error !== want.err)
                  report_mismatch($sformatf("rank_error %b, expected %b",
                                            rsp_rank_error, want.err));
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_UPDATE) begin
               update_total++;
               // an update past the store is dropped
               if (req_position < DEPTH)
                  shadow_store[req_position] = req_new_value[VALUE_BITS-1:0];
            end else begin
               want = kth_smallest(req_position, req_range_end, req_rank_k);
               query_total++;
               if (want.err) rejected_total++;
               owed_answers.push_back(want);
            end
         end
      end
      answers_pending <= owed_answers.size();
   end

endmodule

// ----- verif/dynamic_range_kth_smallest_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_range_kth_smallest_core_tb
// request stimulus and verdict for the k-th smallest core
// ----------------------------------------------------------------------------
// a directed pass hits the rank and range corner cases and the full-depth
// scans, then random updates and short queries work a moving hot window
// the sender runs in bursts with gaps, the receiver stalls in changing modes
// checking is done by kth_smallest_checker beside the core
// ----------------------------------------------------------------------------
module dynamic_range_kth_smallest_core_tb import drk_pkg::*; ();

   localparam int RANDOM_ITEMS   = 76;
   localparam int HOT_SPAN       = 64;
   localparam int SHORT_RANGE    = 32;
   localparam int WIDE_RANGE     = 256;
   localparam int WATCHDOG_LIMIT = 80000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int MAX_RANK       = (1 << RANK_W) - 1;
   localparam int MAX_VALUE      = (1 << KV_W) - 1;

   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_mode_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic              req_opcode     = OP_QUERY;
   logic [POS_W-1:0]  req_position   = '0;
   logic [POS_W-1:0]  req_range_end  = '0;
   logic [KV_W-1:0]   req_new_value  = '0;
   logic [RANK_W-1:0] req_rank_k     = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [KV_W-1:0]   rsp_kth_value;
   logic              rsp_rank_error;

   int          mismatch_count;
   int          answers_pending;
   int          query_total;
   int          update_total;
   int          rejected_total;
   int          burst_left   = 0;
   int          quiet_cycles = 0;
   int          rx_left      = 0;
   rx_mode_type rx_mode      = RX_OPEN;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dynamic_range_kth_smallest_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_range_end  (req_range_end),
      .req_new_value  (req_new_value),
      .req_rank_k     (req_rank_k),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kth_value  (rsp_kth_value),
      .rsp_rank_error (rsp_rank_error)
   );

   kth_smallest_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_range_end   (req_range_end),
      .req_new_value   (req_new_value),
      .req_rank_k      (req_rank_k),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kth_value   (rsp_kth_value),
      .rsp_rank_error  (rsp_rank_error),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending),
      .query_total     (query_total),
      .update_total    (update_total),
      .rejected_total  (rejected_total)
   );

   // response stalls: open, choppy and choked stretches of random length
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(8, 120);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
         default:   rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // watchdog on cycles with no request and no response moved
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d answers owed",
                  quiet_cycles, answers_pending);
         $display("** dynamic_range_kth_smallest_core: FAILED **");
         $finish;
      end
   end

   // one request, with a random gap ahead of each new burst
   task automatic issue(input logic op, input int pos, input int last, input int val,
                        input int rank);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_position  <= POS_W'(pos);
      req_range_end <= POS_W'(last);
      req_new_value <= KV_W'(val);
      req_rank_k    <= RANK_W'(rank);
      do @(posedge clock); while (!req_ready);
   endtask

   // unused fields carry noise
   task automatic issue_update(input int pos, input int val);
      issue(OP_UPDATE, pos, $urandom_range(0, DEPTH - 1), val, $urandom_range(0, MAX_RANK));
   endtask

   task automatic issue_query(input int lo, input int hi, input int rank);
      issue(OP_QUERY, lo, hi, $urandom_range(0, MAX_VALUE), rank);
   endtask

   // values lean toward duplicates and bit extremes
   function automatic int pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return $urandom_range(0, MAX_VALUE);
      if (roll < 6) begin
         case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return MAX_VALUE >> 1;
            3:       return (MAX_VALUE >> 1) + 1;
            default: return MAX_VALUE;
         endcase
      end
      return $urandom_range(0, 15);
   endfunction

   initial begin
      int n;
      int roll;
      int len;
      int lo;
      int hi;
      int hot_base;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, duplicates and every rejection case
      issue_query(0, DEPTH - 1, 1);
      issue_update(0, MAX_VALUE);
      issue_update(DEPTH - 1, 1);
      issue_update(DEPTH / 2, (MAX_VALUE >> 1) + 1);
      issue(OP_UPDATE, 1, DEPTH - 1, 0, MAX_RANK);
      issue_update(10, 7);
      issue_update(11, 7);
      issue_update(12, 7);
      issue_update(13, MAX_VALUE - 1);
      issue_query(0, DEPTH - 1, DEPTH);
      issue_query(0, DEPTH - 1, DEPTH - 1);
      issue_query(0, DEPTH - 1, MAX_RANK);
      issue_query(0, 0, 1);
      issue_query(0, 0, 0);
      issue_query(5, 4, 1);
      issue_query(DEPTH - 1, 0, 1);
      issue_query(10, 13, 3);
      issue_query(10, 13, 5);
      issue_query(DEPTH - 4, DEPTH - 1, 4);
      issue_query(0, 1, 2);
      issue_query(DEPTH - 1, DEPTH - 1, 1);
      issue_update(DEPTH - 1, MAX_VALUE);
      issue_query(DEPTH - 2, DEPTH - 1, 1);
      issue_query(DEPTH - 2, DEPTH - 1, 2);

      // random: mostly updates and short queries in a moving hot window
      hot_base = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 25 == 0) hot_base = $urandom_range(0, DEPTH - HOT_SPAN);
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            issue_update(hot_base + $urandom_range(0, HOT_SPAN - 1), pick_value());
         end else if (roll < 50) begin
            issue_update($urandom_range(0, DEPTH - 1), pick_value());
         end else if (roll < 85) begin
            len = $urandom_range(1, SHORT_RANGE);
            lo  = hot_base + $urandom_range(0, HOT_SPAN - len);
            issue_query(lo, lo + len - 1, $urandom_range(1, len));
         end else if (roll < 88) begin
            len = $urandom_range(1, WIDE_RANGE);
            lo  = $urandom_range(0, DEPTH - len);
            issue_query(lo, lo + len - 1, $urandom_range(1, len));
         end else begin
            len = $urandom_range(1, SHORT_RANGE);
            lo  = hot_base + $urandom_range(0, HOT_SPAN - len);
            case ($urandom_range(0, 2))
               0: issue_query(lo, lo + len - 1, 0);
               1: issue_query(lo, lo + len - 1, $urandom_range(len + 1, MAX_RANK));
               default: begin
                  lo = $urandom_range(1, DEPTH - 1);
                  hi = $urandom_range(0, lo - 1);
                  issue_query(lo, hi, $urandom_range(0, MAX_RANK));
               end
            endcase
         end
      end
      req_valid <= 1'b0;

      // let the owed count take in the last request, drain it, then let any
      // late extra response show up
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d updates and %0d queries, %0d of the queries rejected",
               update_total, query_total, rejected_total);
      $display("mostly short ranges in a moving hot window, a few scans up to full depth");
      if (mismatch_count == 0) begin
         $display("** dynamic_range_kth_smallest_core: PASSED **");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("** dynamic_range_kth_smallest_core: FAILED **");
      end
      $finish;
   end

endmodule
